// File: design/csess_pkg.sv
// Package for the client session table: table size, opcode and status codes,
// and the layout of one stored session record. No dependencies.
package csess_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 5;
    localparam int LIM_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [2:0] {
        OP_REGISTER   = 3'd0,
        OP_UNREGISTER = 3'd1,
        OP_FIND_ID    = 3'd2,
        OP_FIND_CONN  = 3'd3,
        OP_FOCUS      = 3'd4,
        OP_ACK        = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP  = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef struct packed {
        logic [63:0] client_id;
        logic [31:0] connection;
        logic [31:0] focus;
        logic [63:0] ack_replication;
        logic [63:0] ack_tick;
    } t_record;

    localparam int REC_W = $bits(t_record);

endpackage

// File: design/client_session_table_top.sv
// Client session table: bounded table of sessions, one result item per input item.
// Each item is accepted in idle, matched with the RAM read in lookup, then written back.
// A new item is not taken until the lookup / read / write-back sequence on the single
// record RAM is through; a pending result stalls write back until it is taken.
// Reset (synchronous, active low): table empty, next id 1, max_clients 16, no clearing pass.
// Depends on csess_pkg and csess_ram.
module client_session_table_top
    import csess_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_client_id,
    input  logic [31:0] i_connection,
    input  logic [31:0] i_focus_word,
    input  logic [63:0] i_ack_replication,
    input  logic [63:0] i_ack_tick,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_out_client_id,
    output logic [31:0] o_out_connection,
    output logic [31:0] o_out_focus,
    output logic [63:0] o_out_ack_replication,
    output logic [63:0] o_out_ack_tick
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_MOD
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_max;
    logic [CNT_W-1:0]    r_count;
    logic [63:0]         r_next_id;
    logic                r_valid    [TABLE_DEPTH];
    logic [63:0]         r_key_id   [TABLE_DEPTH];
    logic [31:0]         r_key_conn [TABLE_DEPTH];

    logic [2:0]          r_op;
    logic [63:0]         r_cid;
    logic [31:0]         r_conn;
    logic [31:0]         r_focus;
    logic [63:0]         r_arep;
    logic [63:0]         r_atick;

    t_status             r_status;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_out_valid;
    t_status             r_out_status;
    t_record             r_out_rec;

    logic                id_any, conn_any, free_any;
    logic [SLOT_W-1:0]   id_idx, conn_idx, free_idx;
    logic [LIM_W-1:0]    limit;
    t_status             n_status;
    logic [SLOT_W-1:0]   n_slot;

    t_record             ram_rdata;
    t_record             n_rec;
    logic                n_we;
    logic                out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    // parallel match over the key copies, lowest slot wins
    always_comb begin
        id_any   = 1'b0;
        conn_any = 1'b0;
        free_any = 1'b0;
        id_idx   = '0;
        conn_idx = '0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key_id[i] == r_cid)) begin
                id_any = 1'b1;
                id_idx = SLOT_W'(i);
            end
            if (r_valid[i] && (r_key_conn[i] == r_conn)) begin
                conn_any = 1'b1;
                conn_idx = SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        limit = (LIM_W'(r_max) < LIM_W'(TABLE_DEPTH)) ? LIM_W'(r_max) : LIM_W'(TABLE_DEPTH);
        n_status = ST_MISS;
        n_slot   = '0;
        unique case (t_op'(r_op))
            OP_REGISTER: begin
                n_slot = free_idx;
                priority if (LIM_W'(r_count) >= limit || !free_any) begin
                    n_status = ST_FULL;
                end else if (conn_any) begin
                    n_status = ST_DUP;
                end else begin
                    n_status = ST_OK;
                end
            end
            OP_UNREGISTER, OP_FIND_ID, OP_FOCUS, OP_ACK: begin
                n_slot   = id_idx;
                n_status = id_any ? ST_OK : ST_MISS;
            end
            OP_FIND_CONN: begin
                n_slot   = conn_idx;
                n_status = conn_any ? ST_OK : ST_MISS;
            end
            default: begin
                n_status = ST_MISS;
            end
        endcase
    end

    // read-modify-write of the record; the record of the slot is already in ram_rdata
    always_comb begin
        n_rec = ram_rdata;
        n_we  = 1'b0;
        unique case (t_op'(r_op))
            OP_REGISTER: begin
                n_rec.client_id       = r_next_id;
                n_rec.connection      = r_conn;
                n_rec.focus           = r_focus;
                n_rec.ack_replication = '0;
                n_rec.ack_tick        = '0;
                n_we                  = 1'b1;
            end
            OP_FOCUS: begin
                n_rec.focus = r_focus;
                n_we        = 1'b1;
            end
            OP_ACK: begin
                if (r_arep > ram_rdata.ack_replication) begin
                    n_rec.ack_replication = r_arep;
                    n_rec.ack_tick        = r_atick;
                    n_we                  = 1'b1;
                end
            end
            default: begin
                n_we = 1'b0;
            end
        endcase
        if (r_state != S_MOD || !out_free || r_status != ST_OK) begin
            n_we = 1'b0;
        end
    end

    csess_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_slot),
        .i_wdata (n_rec),
        .i_raddr (n_slot),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= CFG_W'(TABLE_DEPTH > 16 ? 16 : TABLE_DEPTH);
            r_count     <= '0;
            r_next_id   <= 64'd1;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && r_state != S_MOD) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_operation;
                        r_cid   <= i_client_id;
                        r_conn  <= i_connection;
                        r_focus <= i_focus_word;
                        r_arep  <= i_ack_replication;
                        r_atick <= i_ack_tick;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_status <= n_status;
                    r_slot   <= n_slot;
                    r_state  <= S_MOD;
                end
                S_MOD: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_rec    <= (r_status == ST_OK) ? n_rec : '0;
                        if (r_status == ST_OK) begin
                            if (t_op'(r_op) == OP_REGISTER) begin
                                r_valid[r_slot]    <= 1'b1;
                                r_key_id[r_slot]   <= r_next_id;
                                r_key_conn[r_slot] <= r_conn;
                                r_count            <= r_count + CNT_W'(1);
                                r_next_id          <= r_next_id + 64'd1;
                            end else if (t_op'(r_op) == OP_UNREGISTER) begin
                                r_valid[r_slot] <= 1'b0;
                                r_count         <= r_count - CNT_W'(1);
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_status              = r_out_status;
    assign o_out_client_id       = r_out_rec.client_id;
    assign o_out_connection      = r_out_rec.connection;
    assign o_out_focus           = r_out_rec.focus;
    assign o_out_ack_replication = r_out_rec.ack_replication;
    assign o_out_ack_tick        = r_out_rec.ack_tick;

`ifndef NO_ASSERTIONS
    logic [TABLE_DEPTH-1:0] valid_vec;
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            valid_vec[i] = r_valid[i];
        end
    end

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) == $countones(valid_vec))
        else $error("entry count out of step with valid bits");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= TABLE_DEPTH)
        else $error("entry count above table depth");

    a_id_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && out_free && r_status == ST_OK
         && t_op'(r_op) == OP_REGISTER)
        |=> r_next_id == $past(r_next_id) + 64'd1)
        else $error("id counter did not advance on register");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK)
        |-> (o_out_client_id == '0 && o_out_connection == '0 && o_out_focus == '0))
        else $error("error result carries entry data");
`endif

endmodule

// File: design/csess_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module csess_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
